// ----- src/tsvf_pkg.sv -----
// Package for the typed sensor value to float converter.
// Holds the type code constants and the decode kind enumeration; no dependencies.
package tsvf_pkg;

    localparam logic [31:0] TC_FLT  = 32'h666C7420; // "flt "
    localparam logic [31:0] TC_SP78 = 32'h73703738; // "sp78"
    localparam logic [31:0] TC_UI8  = 32'h75693820; // "ui8 "
    localparam logic [31:0] TC_UI16 = 32'h75693136; // "ui16"
    localparam logic [31:0] TC_UI32 = 32'h75693332; // "ui32"

    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_P = 8'h70;

    typedef enum logic [2:0] {
        K_NONE,
        K_FLT,
        K_SP78,
        K_UI8,
        K_UI16,
        K_UI32,
        K_FPXY,
        K_SPXY
    } t_kind;

endpackage

// ----- src/tsvf_make_bits.sv -----
// Integer magnitude to IEEE single conversion with round to nearest even.
// Purely combinational; uses no package items.
module tsvf_make_bits (
    input  logic        i_neg,
    input  logic [31:0] i_mag,
    input  logic [3:0]  i_frac,
    output logic [31:0] o_bits
);
    logic [4:0]  msb;
    logic [31:0] norm;
    logic [23:0] keep;
    logic [24:0] rnd;
    logic        lsb;
    logic        guard;
    logic        sticky;
    logic [7:0]  expo;

    always_comb begin
        msb = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_mag[i]) begin
                msb = 5'(i);
            end
        end
    end

    // Left-justify so the leading one sits at bit 31.
    assign norm   = i_mag << (5'd31 - msb);
    assign keep   = norm[31:8];
    assign lsb    = norm[8];
    assign guard  = norm[7];
    assign sticky = |norm[6:0];
    assign rnd    = {1'b0, keep} + 25'(guard && (sticky || lsb));

    always_comb begin
        expo = 8'd127 + 8'(msb) - 8'(i_frac) + 8'(rnd[24]);
        if (i_mag == 32'd0) begin
            o_bits = 32'd0;
        end else if (rnd[24]) begin
            o_bits = {i_neg, expo, 23'd0};
        end else begin
            o_bits = {i_neg, expo, rnd[22:0]};
        end
    end
endmodule

// ----- src/typed_sensor_value_to_float.sv -----
// Top level of the typed sensor value to float converter.
// Uses tsvf_pkg and tsvf_make_bits.
//
// Input channel: i_valid / o_stall with type code, byte count and the first four
// payload bytes. Output channel: o_valid / i_stall with the float bit pattern and
// a valid flag. A beat is taken when valid is high and stall is low.
// Each input beat is captured in an input register, decoded by one pass of
// combinational logic (type match, leading one search, shift, rounding) and
// written into an output register. Throughput is one beat per cycle, limited
// only by the receiver. When the receiver stalls, the output register holds its
// beat and the input register fills; o_stall rises only when both are full, so no
// beat is lost. Synchronous active-low reset empties both registers; there is no
// other state.
module typed_sensor_value_to_float (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_type_code,
    input  logic [5:0]  i_data_size,
    input  logic [31:0] i_data_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_value_bits,
    output logic        o_valid_res
);
    logic        r_in_v;
    logic [31:0] r_t;
    logic [5:0]  r_sz;
    logic [31:0] r_d;
    logic        r_out_v;
    logic [31:0] r_bits;
    logic        r_ok;

    logic        out_load;
    logic        in_load;
    tsvf_pkg::t_kind kind;
    logic [7:0]  c0, c1, c3;
    logic [15:0] hi16;
    logic [3:0]  frac;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] conv;
    logic [31:0] fbits;
    logic [31:0] n_bits;
    logic        n_ok;

    assign out_load = r_in_v && (!r_out_v || !i_stall);
    assign in_load  = !r_in_v || out_load;
    assign o_stall  = !in_load;

    assign c0   = r_t[31:24];
    assign c1   = r_t[23:16];
    assign c3   = r_t[7:0];
    assign hi16 = r_d[31:16];

    always_comb begin
        kind = tsvf_pkg::K_NONE;
        if (c0 == 8'd0 || c1 == 8'd0 || r_t[15:8] == 8'd0 || c3 == 8'd0) begin
            kind = tsvf_pkg::K_NONE;
        end else if (r_t == tsvf_pkg::TC_FLT && r_sz == 6'd4) begin
            kind = tsvf_pkg::K_FLT;
        end else if (r_t == tsvf_pkg::TC_SP78 && r_sz == 6'd2) begin
            kind = tsvf_pkg::K_SP78;
        end else if (r_t == tsvf_pkg::TC_UI8 && r_sz >= 6'd1) begin
            kind = tsvf_pkg::K_UI8;
        end else if (r_t == tsvf_pkg::TC_UI16 && r_sz >= 6'd2) begin
            kind = tsvf_pkg::K_UI16;
        end else if (r_t == tsvf_pkg::TC_UI32 && r_sz >= 6'd4) begin
            kind = tsvf_pkg::K_UI32;
        end else if (c0 == tsvf_pkg::CH_F && c1 == tsvf_pkg::CH_P && r_sz == 6'd2) begin
            kind = tsvf_pkg::K_FPXY;
        end else if (c0 == tsvf_pkg::CH_S && c1 == tsvf_pkg::CH_P && r_sz == 6'd2) begin
            kind = tsvf_pkg::K_SPXY;
        end
    end

    // Fraction digit is hex in either case; anything else means no fraction bits.
    always_comb begin
        frac = 4'd0;
        if (c3 >= 8'h30 && c3 <= 8'h39) begin
            frac = c3[3:0];
        end else if ((c3 >= 8'h61 && c3 <= 8'h66) || (c3 >= 8'h41 && c3 <= 8'h46)) begin
            frac = c3[3:0] + 4'd9;
        end
    end

    always_comb begin
        neg = 1'b0;
        mag = 32'd0;
        case (kind)
            tsvf_pkg::K_SP78, tsvf_pkg::K_SPXY: begin
                neg = hi16[15];
                mag = hi16[15] ? 32'(17'h10000 - {1'b0, hi16}) : {16'd0, hi16};
            end
            tsvf_pkg::K_UI8:  mag = {24'd0, r_d[31:24]};
            tsvf_pkg::K_UI16, tsvf_pkg::K_FPXY: mag = {16'd0, hi16};
            tsvf_pkg::K_UI32: mag = r_d;
            default: mag = 32'd0;
        endcase
    end

    tsvf_make_bits u_make (
        .i_neg  (neg),
        .i_mag  (mag),
        .i_frac ((kind == tsvf_pkg::K_SP78) ? 4'd8 :
                 ((kind == tsvf_pkg::K_FPXY || kind == tsvf_pkg::K_SPXY) ? frac : 4'd0)),
        .o_bits (conv)
    );

    assign fbits = {r_d[7:0], r_d[15:8], r_d[23:16], r_d[31:24]};

    always_comb begin
        n_bits = conv;
        n_ok   = 1'b1;
        case (kind)
            tsvf_pkg::K_NONE: begin
                n_bits = 32'd0;
                n_ok   = 1'b0;
            end
            tsvf_pkg::K_FLT: begin
                if (fbits[30:23] == 8'hFF && fbits[22:0] != 23'd0) begin
                    n_bits = 32'd0;
                    n_ok   = 1'b0;
                end else begin
                    n_bits = fbits;
                end
            end
            default: n_bits = conv;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_v <= i_valid;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_t  <= i_type_code;
            r_sz <= i_data_size;
            r_d  <= i_data_bytes;
        end
        if (out_load) begin
            r_bits <= n_bits;
            r_ok   <= n_ok;
        end
    end

    assign o_valid      = r_out_v;
    assign o_value_bits = r_bits;
    assign o_valid_res  = r_ok;

    // An invalid result always carries a zero pattern.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_value_bits == 32'd0))
        else $error("invalid result with nonzero value");

    // A stalled output beat is never overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_value_bits) && $stable(o_valid_res)))
        else $error("output beat changed under stall");

    // Input stalls only when both stages hold beats.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_v && r_out_v && i_stall))
        else $error("stall without full pipeline");
endmodule
